>>> design/gbn_pkg.sv
// Shared types, sizes and helpers for the go-back-N sender window.
// No dependencies; every other file in this folder imports it.
package gbn_pkg;

    localparam int BUFFER_SLOTS = 8;
    localparam int PAYLOAD_BITS = 32;
    localparam int SEQ_W        = 16;
    localparam int WIN_W        = 4;
    localparam int DATA_W       = 32;
    localparam int SLOT_W       = (BUFFER_SLOTS > 1) ? $clog2(BUFFER_SLOTS) : 1;
    localparam int CNT_W        = $clog2(BUFFER_SLOTS + 1);
    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(4);

    typedef enum logic [1:0] {
        OP_SEND    = 2'd0,
        OP_ACK     = 2'd1,
        OP_TIMEOUT = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        KIND_REFUSED = 3'd0,
        KIND_PKT     = 3'd1,
        KIND_CORRUPT = 3'd2,
        KIND_RANGE   = 3'd3,
        KIND_ACCEPT  = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        TACT_NONE    = 2'd0,
        TACT_START   = 2'd1,
        TACT_STOP    = 2'd2,
        TACT_RESTART = 2'd3
    } t_tact;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_EMIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic cap;       // latch the accepted word
        logic exec;      // run a send or ack, load the output register
        logic rs_start;  // clear the resend index
        logic emit;      // load one resent packet, step the index
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        t_op  op;
        logic has_outs;  // at least one packet outstanding
        logic last_k;    // resend index is on the newest packet
    } t_dp_sts;

    // slot + offset modulo the buffer depth; the sum stays below twice the depth
    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] slot,
                                                   input logic [CNT_W-1:0]  off);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(slot) + (CNT_W + 1)'(off);
        if (sum >= (CNT_W + 1)'(BUFFER_SLOTS)) begin
            sum = sum - (CNT_W + 1)'(BUFFER_SLOTS);
        end
        return SLOT_W'(sum);
    endfunction

    // window_size 0 acts as 1, anything above the buffer depth as the depth
    function automatic logic [CNT_W-1:0] eff_window(input logic [WIN_W-1:0] w);
        logic [CNT_W-1:0] r;
        if (w == '0) begin
            r = CNT_W'(1);
        end else if (int'(w) > BUFFER_SLOTS) begin
            r = CNT_W'(BUFFER_SLOTS);
        end else begin
            r = CNT_W'(w);
        end
        return r;
    endfunction

    function automatic logic [PAYLOAD_BITS-1:0] to_store(input logic [DATA_W-1:0] p);
        logic [PAYLOAD_BITS-1:0] r;
        r = '0;
        for (int i = 0; i < PAYLOAD_BITS && i < DATA_W; i++) begin
            r[i] = p[i];
        end
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] from_store(input logic [PAYLOAD_BITS-1:0] p);
        logic [DATA_W-1:0] r;
        r = '0;
        for (int i = 0; i < PAYLOAD_BITS && i < DATA_W; i++) begin
            r[i] = p[i];
        end
        return r;
    endfunction

endpackage

>>> design/gbn_ctrl.sv
// Controller for the go-back-N sender: sequencing and output valid.
// Depends on gbn_pkg.
module gbn_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output gbn_pkg::t_dp_cmd o_cmd,
    input  gbn_pkg::t_dp_sts i_sts
);
    import gbn_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_sts.op)
                    OP_SEND, OP_ACK: begin
                        if (out_free) begin
                            o_cmd.exec = 1'b1;
                            n_state    = S_IDLE;
                        end
                    end
                    OP_TIMEOUT: begin
                        if (i_sts.has_outs) begin
                            o_cmd.rs_start = 1'b1;
                            n_state        = S_READ;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_READ: n_state = S_EMIT;   // store read data lands this cycle
            S_EMIT: begin
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_sts.last_k ? S_IDLE : S_READ;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (o_cmd.exec || o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

endmodule

>>> design/gbn_dp.sv
// Datapath for the go-back-N sender: window registers, payload store, output register.
// Depends on gbn_pkg.
module gbn_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  gbn_pkg::t_dp_cmd          i_cmd,
    output gbn_pkg::t_dp_sts          o_sts,
    input  logic                      i_cfg_we,
    input  logic [gbn_pkg::WIN_W-1:0] i_cfg_data,
    input  logic [1:0]                i_op,
    input  logic [gbn_pkg::DATA_W-1:0] i_payload,
    input  logic [gbn_pkg::SEQ_W-1:0] i_ack_number,
    input  logic                      i_ack_intact,
    input  logic [gbn_pkg::SEQ_W-1:0] i_expired_timer_seq,
    output logic [2:0]                o_kind,
    output logic [gbn_pkg::SEQ_W-1:0] o_packet_seq,
    output logic [gbn_pkg::DATA_W-1:0] o_packet_data,
    output logic [1:0]                o_timer_action,
    output logic [gbn_pkg::SEQ_W-1:0] o_timer_seq,
    output logic                      o_window_full,
    output logic                      o_last
);
    import gbn_pkg::*;

    // window state
    logic [WIN_W-1:0]  r_win,  n_win;
    logic [SEQ_W-1:0]  r_base, n_base;
    logic [SEQ_W-1:0]  r_next, n_next;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_full, n_full;
    logic [SLOT_W-1:0] r_base_slot, n_base_slot;
    logic [SLOT_W-1:0] r_k, n_k;

    // captured word
    t_op               r_op;
    logic [DATA_W-1:0] r_payload;
    logic [SEQ_W-1:0]  r_ack;
    logic              r_intact;
    logic [SEQ_W-1:0]  r_exp_seq;

    // payload store, no reset
    logic [PAYLOAD_BITS-1:0] r_store [BUFFER_SLOTS];
    logic [PAYLOAD_BITS-1:0] r_rdata;
    logic                    mem_we;
    logic [SLOT_W-1:0]       mem_wa;
    logic [SLOT_W-1:0]       rd_slot;

    // output register
    t_kind             r_kind,  n_kind;
    logic [SEQ_W-1:0]  r_oseq,  n_oseq;
    logic [DATA_W-1:0] r_odata, n_odata;
    t_tact             r_tact,  n_tact;
    logic [SEQ_W-1:0]  r_tseq,  n_tseq;
    logic              r_wf,    n_wf;
    logic              r_last,  n_last;

    logic [CNT_W-1:0]  win;
    logic [SEQ_W-1:0]  adv16;
    logic [CNT_W-1:0]  adv1;
    logic [CNT_W-1:0]  cnt_after;
    logic [CNT_W-1:0]  k_ext;

    assign win     = eff_window(r_win);
    assign adv16   = r_ack - r_base;
    assign adv1    = CNT_W'(adv16) + CNT_W'(1);
    assign k_ext   = CNT_W'(r_k);
    assign rd_slot = slot_add(r_base_slot, k_ext);

    assign o_sts.op       = r_op;
    assign o_sts.has_outs = (r_count != '0);
    assign o_sts.last_k   = ((k_ext + CNT_W'(1)) == r_count);

    always_comb begin
        n_win       = i_cfg_we ? i_cfg_data : r_win;
        n_base      = r_base;
        n_next      = r_next;
        n_count     = r_count;
        n_full      = r_full;
        n_base_slot = r_base_slot;
        n_k         = r_k;
        n_kind      = r_kind;
        n_oseq      = r_oseq;
        n_odata     = r_odata;
        n_tact      = r_tact;
        n_tseq      = r_tseq;
        n_wf        = r_wf;
        n_last      = r_last;
        mem_we      = 1'b0;
        mem_wa      = slot_add(r_base_slot, r_count);
        cnt_after   = r_count;

        if (i_cmd.exec) begin
            n_oseq  = '0;
            n_odata = '0;
            n_tact  = TACT_NONE;
            n_tseq  = '0;
            n_last  = 1'b1;
            n_wf    = r_full;
            if (r_op == OP_SEND) begin
                if (r_full || (r_count >= win)) begin
                    n_full = 1'b1;
                    n_kind = KIND_REFUSED;
                    n_wf   = 1'b1;
                end else begin
                    mem_we    = 1'b1;
                    cnt_after = r_count + CNT_W'(1);
                    n_count   = cnt_after;
                    n_next    = r_next + SEQ_W'(1);
                    n_full    = (cnt_after >= win);
                    n_wf      = n_full;
                    n_kind    = KIND_PKT;
                    n_oseq    = r_next;
                    n_odata   = from_store(to_store(r_payload));
                    if (r_count == '0) begin
                        n_tact = TACT_START;
                        n_tseq = r_next;
                    end
                end
            end else if (!r_intact) begin
                n_kind = KIND_CORRUPT;
            end else if (adv16 >= SEQ_W'(r_count)) begin
                n_kind = KIND_RANGE;
            end else begin
                cnt_after   = r_count - adv1;
                n_count     = cnt_after;
                n_base      = r_base + SEQ_W'(adv1);
                n_base_slot = slot_add(r_base_slot, adv1);
                n_full      = (cnt_after >= win);
                n_wf        = n_full;
                n_kind      = KIND_ACCEPT;
                if (cnt_after == '0) begin
                    n_tact = TACT_STOP;
                    n_tseq = r_base;
                end else begin
                    n_tact = TACT_RESTART;
                    n_tseq = n_base;
                end
            end
        end

        if (i_cmd.rs_start) begin
            n_k = '0;
        end

        if (i_cmd.emit) begin
            n_kind  = KIND_PKT;
            n_oseq  = r_base + SEQ_W'(r_k);
            n_odata = from_store(r_rdata);
            n_tact  = (r_k == '0) ? TACT_RESTART : TACT_NONE;
            n_tseq  = (r_k == '0) ? r_exp_seq : '0;
            n_wf    = r_full;
            n_last  = o_sts.last_k;
            n_k     = r_k + SLOT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win       <= WIN_RESET;
            r_base      <= '0;
            r_next      <= '0;
            r_count     <= '0;
            r_full      <= 1'b0;
            r_base_slot <= '0;
            r_k         <= '0;
        end else begin
            r_win       <= n_win;
            r_base      <= n_base;
            r_next      <= n_next;
            r_count     <= n_count;
            r_full      <= n_full;
            r_base_slot <= n_base_slot;
            r_k         <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_op      <= t_op'(i_op);
            r_payload <= i_payload;
            r_ack     <= i_ack_number;
            r_intact  <= i_ack_intact;
            r_exp_seq <= i_expired_timer_seq;
        end
        r_kind  <= n_kind;
        r_oseq  <= n_oseq;
        r_odata <= n_odata;
        r_tact  <= n_tact;
        r_tseq  <= n_tseq;
        r_wf    <= n_wf;
        r_last  <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_wa] <= to_store(r_payload);
        end
        r_rdata <= r_store[rd_slot];
    end

    assign o_kind         = r_kind;
    assign o_packet_seq   = r_oseq;
    assign o_packet_data  = r_odata;
    assign o_timer_action = r_tact;
    assign o_timer_seq    = r_tseq;
    assign o_window_full  = r_wf;
    assign o_last         = r_last;

endmodule

>>> design/go_back_n_sender_window_top.sv
// Go-back-N sender window, top level. An input word is captured first; a send or ack
// then loads its result word into the output register, and a timeout resends each
// outstanding packet as a store read, then an output load. Output stalls hold both;
// one input word is handled at a time.
// Input is taken while an earlier result still waits in the output register.
// Reset is synchronous, active low: window empty, sequence numbers 0, window_size 4.
module go_back_n_sender_window_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: window_size
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // payload[31:0], ack_number[47:32],
                                       // ack_intact[48], expired_timer_seq[64:49], zero
    input  logic [1:0]  s_axis_tuser,  // operation[1:0]
    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // packet_seq[15:0], packet_data[47:16],
                                       // timer_action[49:48], timer_seq[65:50],
                                       // window_full[66], zero
    output logic [2:0]  m_axis_tuser,  // kind[2:0]
    output logic        m_axis_tlast   // last result of this input word
);
    import gbn_pkg::*;

    t_dp_cmd           cmd;
    t_dp_sts           sts;
    logic [SEQ_W-1:0]  packet_seq;
    logic [DATA_W-1:0] packet_data;
    logic [1:0]        timer_action;
    logic [SEQ_W-1:0]  timer_seq;
    logic              window_full;

    // window_size may be written at any time; it is only sampled on a send or ack
    assign o_cfg_ready = 1'b1;

    gbn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    gbn_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_cfg_we            (i_cfg_valid),
        .i_cfg_data          (i_cfg_data),
        .i_op                (s_axis_tuser),
        .i_payload           (s_axis_tdata[31:0]),
        .i_ack_number        (s_axis_tdata[47:32]),
        .i_ack_intact        (s_axis_tdata[48]),
        .i_expired_timer_seq (s_axis_tdata[64:49]),
        .o_kind              (m_axis_tuser),
        .o_packet_seq        (packet_seq),
        .o_packet_data       (packet_data),
        .o_timer_action      (timer_action),
        .o_timer_seq         (timer_seq),
        .o_window_full       (window_full),
        .o_last              (m_axis_tlast)
    );

    assign m_axis_tdata = {5'b0, window_full, timer_seq, timer_action, packet_data, packet_seq};

    // a refused send always reports the window as full
    a_refuse_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_REFUSED) |-> m_axis_tdata[66])
        else $error("refused send without window_full");

    // only resends produce multi-word bursts
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != KIND_PKT) |-> m_axis_tlast)
        else $error("non-packet result not marked last");

    // a timer start only comes with a freshly sent packet
    a_start_pkt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[49:48] == TACT_START)
            |-> (m_axis_tuser == KIND_PKT) && m_axis_tlast)
        else $error("timer start on a non-send result");

    // one word in flight: the input side closes after a word is taken
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second word taken while busy");

endmodule

>>> verif/gbn_sender_checker.sv
// Checker for the go-back-N sender window: predicts every result word from the
// configuration and input words it sees and compares. Depends on gbn_pkg.
module gbn_sender_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [71:0] i_in_data,    // payload, ack_number, ack_intact, expired_timer_seq
    input  logic [1:0]  i_in_user,    // operation
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [71:0] i_out_data,   // packet_seq, packet_data, timer_action, timer_seq,
                                      // window_full
    input  logic [2:0]  i_out_user,   // kind
    input  logic        i_out_last,
    output int          o_errors,
    output int          o_pending,
    output int          o_results,
    output logic [15:0] o_oldest_seq,
    output logic [15:0] o_fresh_seq
);
    timeunit 1ns;
    timeprecision 1ps;
    import gbn_pkg::*;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] seq;
        logic [31:0] data;
        t_tact       tact;
        logic [15:0] tseq;
        logic        full;
        logic        last;
    } t_result;

    t_result     due_results [$];
    logic [3:0]  window_reg;
    logic [15:0] oldest_seq;
    logic [15:0] fresh_seq;
    logic        window_shut;
    int          head_slot;
    logic [31:0] sent_words [BUFFER_SLOTS];
    int          mismatch_prints;

    initial begin
        o_errors        = 0;
        o_results       = 0;
        o_pending       = 0;
        mismatch_prints = 0;
    end

    // 0 behaves as 1, anything past the buffer depth as the depth
    function automatic int usable_window();
        if (window_reg == '0) begin
            return 1;
        end else if (int'(window_reg) > BUFFER_SLOTS) begin
            return BUFFER_SLOTS;
        end
        return int'(window_reg);
    endfunction

    task automatic note_result(input t_kind kind, input logic [15:0] seq,
                               input logic [31:0] data, input t_tact tact,
                               input logic [15:0] tseq, input logic last);
        t_result r;
        r.kind = kind;
        r.seq  = seq;
        r.data = data;
        r.tact = tact;
        r.tseq = tseq;
        r.full = window_shut;
        r.last = last;
        due_results.push_back(r);
    endtask

    task automatic sender_step(input t_op op, input logic [71:0] d);
        logic [31:0] payload;
        logic [15:0] ack;
        logic [15:0] tag;
        logic [15:0] outs;
        logic [15:0] adv;
        logic [15:0] old_oldest;
        logic        intact;
        int          win;
        int          n;
        payload = d[31:0];
        ack     = d[47:32];
        intact  = d[48];
        tag     = d[64:49];
        win     = usable_window();
        outs    = fresh_seq - oldest_seq;
        case (op)
            OP_SEND: begin
                if (window_shut || int'(outs) >= win) begin
                    window_shut = 1'b1;
                    note_result(KIND_REFUSED, '0, '0, TACT_NONE, '0, 1'b1);
                end else begin
                    sent_words[(head_slot + int'(outs)) % BUFFER_SLOTS] = payload;
                    fresh_seq   = fresh_seq + 16'd1;
                    window_shut = (int'(outs) + 1) >= win;
                    if (outs == '0) begin
                        note_result(KIND_PKT, fresh_seq - 16'd1, payload, TACT_START,
                                    fresh_seq - 16'd1, 1'b1);
                    end else begin
                        note_result(KIND_PKT, fresh_seq - 16'd1, payload, TACT_NONE, '0, 1'b1);
                    end
                end
            end
            OP_ACK: begin
                adv = ack - oldest_seq;
                if (!intact) begin
                    note_result(KIND_CORRUPT, '0, '0, TACT_NONE, '0, 1'b1);
                end else if (adv >= outs) begin
                    note_result(KIND_RANGE, '0, '0, TACT_NONE, '0, 1'b1);
                end else begin
                    old_oldest  = oldest_seq;
                    oldest_seq  = ack + 16'd1;
                    head_slot   = (head_slot + int'(adv) + 1) % BUFFER_SLOTS;
                    window_shut = (int'(outs) - int'(adv) - 1) >= win;
                    if (oldest_seq == fresh_seq) begin
                        note_result(KIND_ACCEPT, '0, '0, TACT_STOP, old_oldest, 1'b1);
                    end else begin
                        note_result(KIND_ACCEPT, '0, '0, TACT_RESTART, oldest_seq, 1'b1);
                    end
                end
            end
            OP_TIMEOUT: begin
                // resend everything outstanding; nothing at all when the window is empty
                n = (int'(outs) > BUFFER_SLOTS) ? BUFFER_SLOTS : int'(outs);
                for (int k = 0; k < n; k++) begin
                    note_result(KIND_PKT, oldest_seq + 16'(k),
                                sent_words[(head_slot + k) % BUFFER_SLOTS],
                                (k == 0) ? TACT_RESTART : TACT_NONE,
                                (k == 0) ? tag : 16'd0, k == n - 1);
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            o_errors++;
            if (mismatch_prints < 100) begin
                mismatch_prints++;
                $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            window_reg  = WIN_RESET;
            oldest_seq  = '0;
            fresh_seq   = '0;
            window_shut = 1'b0;
            head_slot   = 0;
            due_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                window_reg = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                sender_step(t_op'(i_in_user), i_in_data);
            end
            if (i_out_valid && i_out_ready) begin
                o_results++;
                if (due_results.size() == 0) begin
                    o_errors++;
                    $error("result word kind 'h%0h with nothing due", i_out_user);
                end else begin
                    want = due_results.pop_front();
                    compare_field("kind", 32'(want.kind), 32'(i_out_user));
                    compare_field("packet_seq", 32'(want.seq), 32'(i_out_data[15:0]));
                    compare_field("packet_data", want.data, i_out_data[47:16]);
                    compare_field("timer_action", 32'(want.tact), 32'(i_out_data[49:48]));
                    compare_field("timer_seq", 32'(want.tseq), 32'(i_out_data[65:50]));
                    compare_field("window_full", 32'(want.full), 32'(i_out_data[66]));
                    compare_field("last", 32'(want.last), 32'(i_out_last));
                end
            end
        end
        o_pending    = due_results.size();
        o_oldest_seq = oldest_seq;
        o_fresh_seq  = fresh_seq;
    end

endmodule

>>> verif/testbench.sv
// Top of the go-back-N sender window testbench: clock, reset, stimulus and verdict.
// Depends on gbn_pkg, go_back_n_sender_window_top and gbn_sender_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import gbn_pkg::*;

    localparam int HOLD_CYCLES  = 400;    // one long result hold-off
    localparam int IDLE_LIMIT   = 4000;   // cycles with no word moving anywhere
    localparam int SETTLE       = 8;      // covers a word that gives no result
    localparam int RANDOM_WORDS = 320;
    localparam int PHASES       = 8;

    // how the ack number of an ack word is chosen just before it goes out
    localparam int ACK_ASIS  = 0;   // keep the random number
    localparam int ACK_SOME  = 1;   // anywhere in the outstanding range
    localparam int ACK_ALL   = 2;   // newest outstanding packet
    localparam int ACK_BASE  = 3;   // oldest outstanding packet only
    localparam int ACK_ABOVE = 4;   // at or just past the next sequence number
    localparam int ACK_BELOW = 5;   // just under the window base

    typedef struct {
        t_op         op;
        logic [31:0] payload;
        logic [15:0] ack;
        logic        intact;
        logic [15:0] tseq;
    } t_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // payload[31:0], ack_number[47:32], ack_intact[48],
                                 // expired_timer_seq[64:49], zero
    logic [1:0]  s_axis_tuser;   // operation[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;   // packet_seq[15:0], packet_data[47:16],
                                 // timer_action[49:48], timer_seq[65:50], window_full[66]
    logic [2:0]  m_axis_tuser;   // kind[2:0]
    logic        m_axis_tlast;

    // from the checker: verdict, backlog and the predicted window edges
    int          errors;
    int          pending;
    int          results;
    logic [15:0] oldest;
    logic [15:0] fresh;

    bit          tx_gaps;
    bit          rx_gaps;
    bit          hold_req;
    int          words_in;
    int          cfg_writes;
    int          wrap_rounds;

    go_back_n_sender_window_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    gbn_sender_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_user   (m_axis_tuser),
        .i_out_last   (m_axis_tlast),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_results    (results),
        .o_oldest_seq (oldest),
        .o_fresh_seq  (fresh)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    endfunction

    // every field random, so unused fields toggle too; payload extremes now and then
    function automatic t_word random_word(input t_op op);
        t_word w;
        w.op      = op;
        w.payload = $urandom;
        w.ack     = 16'($urandom);
        w.intact  = 1'($urandom);
        w.tseq    = 16'($urandom);
        case ($urandom_range(0, 15))
            0: w.payload = '0;
            1: w.payload = '1;
            default: begin
            end
        endcase
        return w;
    endfunction

    // Drives one input word from a falling edge and holds it until taken.
    // Valid is left high on return; the next call or a drain decides what follows.
    task automatic push_word(input t_word w, input int ack_mode);
        int          gap;
        logic [15:0] outs;
        gap = (tx_gaps && $urandom_range(0, 2) == 0) ? gap_len() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        // the window edges are settled here: the checker moved them at the last rising edge
        outs = fresh - oldest;
        case (ack_mode)
            ACK_SOME: begin
                if (outs != '0) begin
                    w.ack = oldest + 16'($urandom_range(0, int'(outs) - 1));
                end
            end
            ACK_ALL:   w.ack = fresh - 16'd1;
            ACK_BASE:  w.ack = oldest;
            ACK_ABOVE: w.ack = fresh + 16'($urandom_range(0, 3));
            ACK_BELOW: w.ack = oldest - 16'($urandom_range(1, 4));
            default: begin
            end
        endcase
        s_axis_tdata  <= {7'd0, w.tseq, w.intact, w.ack, w.payload};
        s_axis_tuser  <= w.op;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        words_in++;
    endtask

    task automatic offer(input t_op op, input int ack_mode, input logic intact);
        t_word w;
        w = random_word(op);
        if (op == OP_ACK) begin
            w.intact = intact;
        end
        push_word(w, ack_mode);
    endtask

    // sender pauses until every due result is in, then waits out SETTLE
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_window(input logic [3:0] size);
        drain();
        i_cfg_data  <= size;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // weighted towards well-formed traffic: sends and in-range acks, with
    // timeouts and a tail of corrupt, stray and unknown words
    task automatic random_traffic();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            offer(OP_SEND, ACK_ASIS, 1'b1);
        end else if (pick < 63) begin
            offer(OP_ACK, ACK_SOME, 1'b1);
        end else if (pick < 71) begin
            offer(OP_ACK, ACK_ALL, 1'b1);
        end else if (pick < 79) begin
            offer(OP_TIMEOUT, ACK_ASIS, 1'b1);
        end else if (pick < 84) begin
            offer(OP_ACK, ACK_ASIS, 1'($urandom));
        end else if (pick < 89) begin
            offer(OP_ACK, ACK_SOME, 1'b0);
        end else if (pick < 93) begin
            offer(OP_ACK, ACK_ABOVE, 1'b1);
        end else if (pick < 97) begin
            offer(OP_ACK, ACK_BELOW, 1'b1);
        end else begin
            offer(OP_NONE, ACK_ASIS, 1'b1);
        end
    endtask

    // Result side: random ready runs and gaps, plus one long hold-off on request.
    // One assignment to tready per falling edge.
    initial begin : receiver
        int stall_left;
        int run_left;
        stall_left    = 0;
        run_left      = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
                run_left   = 0;
            end else if (rx_gaps && stall_left == 0 && run_left == 0) begin
                if ($urandom_range(0, 3) == 0) begin
                    stall_left = gap_len();
                end else begin
                    run_left = $urandom_range(1, 12);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                if (run_left > 0) begin
                    run_left--;
                end
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run once no word has moved on any channel for too long.
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $error("no word moved for %0d cycles", IDLE_LIMIT);
        $display("testbench: done, errors");
        $finish;
    end

    initial begin : stimulus
        t_word      w;
        logic [3:0] sizes [PHASES];
        int         rounds;
        sizes         = '{4'd1, 4'd8, 4'd3, 4'd0, 4'd15, 4'd6, 4'd2, 4'd0};
        sizes[7]      = 4'($urandom_range(0, 15));
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_SEND;
        tx_gaps       = 1'b1;
        rx_gaps       = 1'b1;
        hold_req      = 1'b0;
        words_in      = 0;
        cfg_writes    = 0;
        wrap_rounds   = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed part, window at its reset size of 4 ---
        offer(OP_TIMEOUT, ACK_ASIS, 1'b1);   // empty window: no timer, no results
        offer(OP_NONE, ACK_ASIS, 1'b1);      // unknown operation, ignored
        offer(OP_ACK, ACK_ASIS, 1'b0);       // corrupt ack
        offer(OP_ACK, ACK_ASIS, 1'b1);       // intact but nothing outstanding
        w = random_word(OP_SEND);
        w.payload = '0;
        push_word(w, ACK_ASIS);              // first packet starts the timer
        w.payload = '1;
        push_word(w, ACK_ASIS);
        offer(OP_SEND, ACK_ASIS, 1'b1);
        offer(OP_SEND, ACK_ASIS, 1'b1);      // window now full
        offer(OP_SEND, ACK_ASIS, 1'b1);      // refused
        w = random_word(OP_TIMEOUT);
        w.tseq = '1;
        push_word(w, ACK_ASIS);              // four packets resent
        offer(OP_ACK, ACK_ABOVE, 1'b1);      // at or just past next sequence number
        offer(OP_ACK, ACK_BELOW, 1'b1);      // just under the base
        offer(OP_ACK, ACK_BASE, 1'b1);       // partial ack: timer restarts
        offer(OP_ACK, ACK_ALL, 1'b1);        // everything acked: timer stops

        // window_size 0 behaves as a window of one
        set_window(4'd0);
        offer(OP_SEND, ACK_ASIS, 1'b1);
        offer(OP_SEND, ACK_ASIS, 1'b1);
        offer(OP_ACK, ACK_ALL, 1'b1);

        // window_size 15 clips to the buffer depth; a timeout then gives eight words
        set_window(4'd15);
        repeat (8) offer(OP_SEND, ACK_ASIS, 1'b1);
        offer(OP_TIMEOUT, ACK_ASIS, 1'b1);

        // shrink the window under eight outstanding packets
        set_window(4'd2);
        offer(OP_SEND, ACK_ASIS, 1'b1);
        offer(OP_ACK, ACK_BASE, 1'b1);
        offer(OP_ACK, ACK_ALL, 1'b1);

        // --- a few full windows back to back, each closed by one ack ---
        set_window(4'd8);
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        rounds  = 4;
        repeat (rounds) begin
            repeat (8) offer(OP_SEND, ACK_ASIS, 1'b1);
            offer(OP_ACK, ACK_ALL, 1'b1);
            wrap_rounds++;
        end

        // --- random part, a new window size per phase ---
        for (int p = 0; p < PHASES; p++) begin
            set_window(sizes[p]);
            tx_gaps = (p % 3) != 0;
            rx_gaps = (p % 4) != 1;
            if (p == 2) begin
                // long result hold-off while words keep coming: the block backs up
                tx_gaps  = 1'b0;
                hold_req = 1'b1;
                repeat (24) random_traffic();
                tx_gaps = 1'b1;
            end
            repeat (RANDOM_WORDS / PHASES) random_traffic();
        end

        drain();
        $display("run covered: %0d input words, %0d result words, %0d window_size writes",
                 words_in, results, cfg_writes);
        $display("run covered: %0d full windows sent back to back, next sequence %0d",
                 wrap_rounds, fresh);
        if (errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
